// ===== src/srt_pkg.sv =====
// symbol range table package: sizes, operation and status codes, entry type
// shared by every module of the symbol_range_table block; no dependencies
`timescale 1ns / 1ps

package srt_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int ADDR_BITS   = 48;
   localparam int END_BITS    = ADDR_BITS + 1;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int NAME_W      = 32;
   localparam int LEN_W       = 32;
   localparam int OFF_W       = 32;

   // operation codes on req_func
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   // result codes on rsp_status
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SKIPPED   = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // symbol type nibble for a function
   localparam logic [3:0] SYM_TYPE_FUNC = 4'd2;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [END_BITS-1:0]  stop;
      logic [NAME_W-1:0]    name;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic      rd_en;
      logic [IDX_W-1:0] rd_idx;
   } ram_ctl_type;

endpackage

// ===== src/srt_ram.sv =====
// range table storage: one write port, one read port with registered data
// depends on srt_pkg for the entry type and table depth
`timescale 1ns / 1ps

module srt_ram (
   input  logic                      clock,
   input  srt_pkg::ram_ctl_type      ctl,
   input  srt_pkg::entry_type        wr_data,
   output srt_pkg::entry_type        rd_data
);

   srt_pkg::entry_type entry_mem_ff [srt_pkg::MAX_ENTRIES];
   srt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[ctl.wr_idx] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= entry_mem_ff[ctl.rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/srt_match.sv =====
// range compare for one stored entry: start <= address < end, and the offset
// depends on srt_pkg for the entry type and widths
`timescale 1ns / 1ps

module srt_match (
   input  logic [srt_pkg::ADDR_BITS-1:0] addr,
   input  srt_pkg::entry_type            entry,
   output logic                          hit,
   output logic [srt_pkg::OFF_W-1:0]     offset
);

   logic [srt_pkg::ADDR_BITS-1:0] diff;

   assign diff   = addr - entry.start;
   assign hit    = (addr >= entry.start) && ({1'b0, addr} < entry.stop);
   assign offset = srt_pkg::OFF_W'(diff);

endmodule

// ===== src/symbol_range_table.sv =====
// symbol range table top level: sequencer, result register, storage and compare
// depends on srt_pkg, srt_ram and srt_match
`timescale 1ns / 1ps

// Holds up to MAX_ENTRIES function address ranges in one synchronous memory.
// A clear or load transaction has its result in the output register on the
// cycle after acceptance. A lookup walks the stored entries from the newest to
// the oldest through the single memory read port: it issues the first read,
// then examines one entry per cycle until a hit or the oldest entry, and then
// registers the result; an empty table answers with not found on the cycle
// after acceptance. One transaction is in flight at a time; req_stall is high
// during a lookup and while a result waits under rsp_stall. No clearing pass
// is needed after reset: only entries below the fill count are ever read.

module symbol_range_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic [7:0]                     req_entry_info,
   input  logic [srt_pkg::ADDR_BITS-1:0]  req_entry_start,
   input  logic [srt_pkg::LEN_W-1:0]      req_entry_length,
   input  logic [srt_pkg::NAME_W-1:0]     req_entry_name_ref,
   input  logic [srt_pkg::ADDR_BITS-1:0]  req_query_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [srt_pkg::NAME_W-1:0]     rsp_found_name_ref,
   output logic [srt_pkg::OFF_W-1:0]      rsp_found_offset
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                          state_ff, state_in;
   logic [srt_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [srt_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic                          pend_ff, pend_in;
   logic [srt_pkg::ADDR_BITS-1:0] addr_ff, addr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    status_ff;
   logic [srt_pkg::NAME_W-1:0]    name_ff;
   logic [srt_pkg::OFF_W-1:0]     offset_ff;

   logic                          res_load;
   logic [1:0]                    res_status;
   logic [srt_pkg::NAME_W-1:0]    res_name;
   logic [srt_pkg::OFF_W-1:0]     res_offset;

   srt_pkg::ram_ctl_type          ram_ctl;
   srt_pkg::entry_type            wr_data;
   srt_pkg::entry_type            rd_data;

   logic                          req_accept;
   logic                          out_free;
   logic                          entry_ok;
   logic                          table_full;
   logic [srt_pkg::CNT_W-1:0]     idx_m1;
   logic                          hit;
   logic [srt_pkg::OFF_W-1:0]     hit_offset;

   srt_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   srt_match u_match (
      .addr   (addr_ff),
      .entry  (rd_data),
      .hit    (hit),
      .offset (hit_offset)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign entry_ok   = (req_entry_info[3:0] == srt_pkg::SYM_TYPE_FUNC) &&
                       (req_entry_length != '0) && (req_entry_name_ref != '0);
   assign table_full = (count_ff == srt_pkg::CNT_W'(srt_pkg::MAX_ENTRIES));
   assign idx_m1     = idx_ff - srt_pkg::CNT_W'(1);

   assign wr_data.start = req_entry_start;
   assign wr_data.stop  = {1'b0, req_entry_start} +
                          srt_pkg::END_BITS'(req_entry_length);
   assign wr_data.name  = req_entry_name_ref;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      addr_in        = addr_ff;
      ram_ctl.wr_en  = 1'b0;
      ram_ctl.wr_idx = count_ff[srt_pkg::IDX_W-1:0];
      ram_ctl.rd_en  = 1'b0;
      ram_ctl.rd_idx = idx_m1[srt_pkg::IDX_W-1:0];
      res_load       = 1'b0;
      res_status     = srt_pkg::STATUS_OK;
      res_name       = '0;
      res_offset     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_func)
                  srt_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                     res_load = 1'b1;
                  end
                  srt_pkg::FUNC_LOAD: begin
                     res_load = 1'b1;
                     if (!entry_ok) begin
                        res_status = srt_pkg::STATUS_SKIPPED;
                     end else if (table_full) begin
                        res_status = srt_pkg::STATUS_FULL;
                     end else begin
                        ram_ctl.wr_en = 1'b1;
                        count_in      = count_ff + srt_pkg::CNT_W'(1);
                     end
                  end
                  srt_pkg::FUNC_LOOKUP: begin
                     addr_in = req_query_address;
                     if (count_ff == '0) begin
                        res_load   = 1'b1;
                        res_status = srt_pkg::STATUS_NOT_FOUND;
                     end else begin
                        state_in = S_SCAN;
                        idx_in   = count_ff;
                        pend_in  = 1'b0;
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // idx_ff names the entry whose data sits in the read register
            if (!pend_ff) begin
               ram_ctl.rd_en = 1'b1;
               idx_in        = idx_m1;
               pend_in       = 1'b1;
            end else if (hit) begin
               if (out_free) begin
                  res_load   = 1'b1;
                  res_name   = rd_data.name;
                  res_offset = hit_offset;
                  state_in   = S_IDLE;
                  pend_in    = 1'b0;
               end
            end else if (idx_ff == '0) begin
               if (out_free) begin
                  res_load   = 1'b1;
                  res_status = srt_pkg::STATUS_NOT_FOUND;
                  state_in   = S_IDLE;
                  pend_in    = 1'b0;
               end
            end else begin
               ram_ctl.rd_en = 1'b1;
               idx_in        = idx_m1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      if (res_load) begin
         status_ff <= res_status;
         name_ff   <= res_name;
         offset_ff <= res_offset;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_name_ref = name_ff;
   assign rsp_found_offset   = offset_ff;

endmodule

// ===== src/srt_checker.sv =====
// port-level checks for symbol_range_table, attached by a bind statement
// depends on srt_pkg for codes and widths
`timescale 1ns / 1ps

module srt_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic [7:0]                     req_entry_info,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   input  logic [srt_pkg::NAME_W-1:0]     rsp_found_name_ref,
   input  logic [srt_pkg::OFF_W-1:0]      rsp_found_offset
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_found_name_ref) && $stable(rsp_found_offset))
      else $error("stalled result changed");

   // no new transaction while a result is blocked
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_valid && rsp_stall |-> req_stall)
      else $error("transaction accepted while result blocked");

   // clear answers on the next cycle
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == srt_pkg::FUNC_CLEAR |=>
         rsp_valid && rsp_status == srt_pkg::STATUS_OK)
      else $error("clear result missing");

   // a non-function symbol is skipped
   a_load_skip: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_func == srt_pkg::FUNC_LOAD &&
         req_entry_info[3:0] != srt_pkg::SYM_TYPE_FUNC |=>
         rsp_valid && rsp_status == srt_pkg::STATUS_SKIPPED)
      else $error("wrong load result for non-function symbol");

   // only a found lookup carries name and offset
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != srt_pkg::STATUS_OK |->
         rsp_found_name_ref == '0 && rsp_found_offset == '0)
      else $error("nonzero fields on a result without a match");

endmodule

bind symbol_range_table srt_checker u_srt_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench for symbol_range_table: a directed table, then episodes of clears,
// loads and lookups checked against a behavioral model of the range table
// depends on srt_pkg and the symbol_range_table rtl

module testbench;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [srt_pkg::ADDR_BITS-1:0] MAX_ADDR = '1;

   typedef struct packed {
      logic [1:0]                    func;
      logic [7:0]                    info;
      logic [srt_pkg::ADDR_BITS-1:0] start;
      logic [srt_pkg::LEN_W-1:0]     length;
      logic [srt_pkg::NAME_W-1:0]    name_ref;
      logic [srt_pkg::ADDR_BITS-1:0] address;
   } sym_req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [srt_pkg::NAME_W-1:0] name_ref;
      logic [srt_pkg::OFF_W-1:0]  offset;
   } sym_rsp_type;

   typedef struct packed {
      sym_req_type item;
      bit          typed;
      sym_rsp_type want;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_func;
   logic [7:0]                    req_entry_info;
   logic [srt_pkg::ADDR_BITS-1:0] req_entry_start;
   logic [srt_pkg::LEN_W-1:0]     req_entry_length;
   logic [srt_pkg::NAME_W-1:0]    req_entry_name_ref;
   logic [srt_pkg::ADDR_BITS-1:0] req_query_address;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_status;
   logic [srt_pkg::NAME_W-1:0]    rsp_found_name_ref;
   logic [srt_pkg::OFF_W-1:0]     rsp_found_offset;

   // behavioral copy of the range table
   logic [srt_pkg::ADDR_BITS-1:0] model_start [srt_pkg::MAX_ENTRIES];
   logic [srt_pkg::END_BITS-1:0]  model_end [srt_pkg::MAX_ENTRIES];
   logic [srt_pkg::NAME_W-1:0]    model_name [srt_pkg::MAX_ENTRIES];
   int                            model_count;

   sym_rsp_type                   pending_rsp [$];
   stim_row_type                  directed_rows [$];
   int                            error_count;
   int                            done_count, skipped_count, full_count, miss_count;
   int                            fill_count;
   bit                            hold_off_req;
   int                            burst_left;
   int                            stall_mode, mode_left;
   logic [srt_pkg::ADDR_BITS-1:0] cluster_base;

   symbol_range_table DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_entry_info     (req_entry_info),
      .req_entry_start    (req_entry_start),
      .req_entry_length   (req_entry_length),
      .req_entry_name_ref (req_entry_name_ref),
      .req_query_address  (req_query_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_name_ref (rsp_found_name_ref),
      .rsp_found_offset   (rsp_found_offset)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // applies one transaction to the model table and returns its result
   function automatic sym_rsp_type resolve_symbol(sym_req_type r);
      sym_rsp_type                  res;
      logic [srt_pkg::END_BITS-1:0] s_ext, a_ext, e_ext, span, delta;
      res.status   = srt_pkg::STATUS_OK;
      res.name_ref = '0;
      res.offset   = '0;
      case (r.func)
         srt_pkg::FUNC_CLEAR: model_count = 0;
         srt_pkg::FUNC_LOAD: begin
            if (r.info[3:0] != srt_pkg::SYM_TYPE_FUNC || r.length == '0 ||
                r.name_ref == '0) begin
               res.status = srt_pkg::STATUS_SKIPPED;
            end else if (model_count >= srt_pkg::MAX_ENTRIES) begin
               res.status = srt_pkg::STATUS_FULL;
            end else begin
               e_ext = {1'b0, r.start};
               e_ext = e_ext + srt_pkg::END_BITS'(r.length);
               model_start[model_count] = r.start;
               model_end[model_count]   = e_ext;
               model_name[model_count]  = r.name_ref;
               model_count++;
            end
         end
         srt_pkg::FUNC_LOOKUP: begin
            res.status = srt_pkg::STATUS_NOT_FOUND;
            a_ext = {1'b0, r.address};
            // newest entry wins
            for (int i = model_count - 1; i >= 0; i--) begin
               s_ext = {1'b0, model_start[i]};
               span  = model_end[i] - s_ext;
               delta = a_ext - s_ext;
               if (a_ext >= s_ext && delta < span) begin
                  res.status   = srt_pkg::STATUS_OK;
                  res.name_ref = model_name[i];
                  res.offset   = delta[srt_pkg::OFF_W-1:0];
                  break;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [srt_pkg::ADDR_BITS-1:0] rand_addr();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return MAX_ADDR;
         default: return srt_pkg::ADDR_BITS'({$urandom, $urandom});
      endcase
   endfunction

   function automatic sym_req_type noise_item(logic [1:0] f);
      sym_req_type r;
      r.func     = f;
      r.info     = 8'($urandom);
      r.start    = rand_addr();
      r.length   = $urandom;
      r.name_ref = $urandom;
      r.address  = rand_addr();
      return r;
   endfunction

   function automatic sym_req_type make_load(bit good_entry);
      sym_req_type r;
      r = noise_item(srt_pkg::FUNC_LOAD);
      // clustered starts make overlapping ranges
      if ($urandom_range(0, 1))
         r.start = cluster_base + srt_pkg::ADDR_BITS'($urandom_range(0, 'hFFFF));
      if ($urandom_range(0, 3) != 0)
         r.length = $urandom_range(1, 'h2000);
      if (good_entry) begin
         r.info[3:0] = srt_pkg::SYM_TYPE_FUNC;
         if (r.length == '0) r.length = 32'd1;
         if (r.name_ref == '0) r.name_ref = 32'd1;
      end else begin
         case ($urandom_range(0, 2))
            0: if (r.info[3:0] == srt_pkg::SYM_TYPE_FUNC)
                  r.info[3:0] = 4'($urandom_range(3, 15));
            1: r.length = '0;
            default: r.name_ref = '0;
         endcase
      end
      return r;
   endfunction

   function automatic sym_req_type make_lookup();
      sym_req_type                   r;
      int                            idx;
      logic [srt_pkg::ADDR_BITS-1:0] base;
      logic [srt_pkg::END_BITS-1:0]  span;
      r = noise_item(srt_pkg::FUNC_LOOKUP);
      if (model_count != 0 && $urandom_range(0, 9) != 0) begin
         idx  = $urandom_range(0, model_count - 1);
         base = model_start[idx];
         span = model_end[idx] - {1'b0, base};
         case ($urandom_range(0, 4))
            0:       r.address = base;
            1:       r.address = srt_pkg::ADDR_BITS'(base + span - 1);
            2:       r.address = srt_pkg::ADDR_BITS'(base + span);
            3:       r.address = base - 1;
            default: r.address = srt_pkg::ADDR_BITS'(base + ({$urandom} % span));
         endcase
      end
      return r;
   endfunction

   // sender: bursts of back-to-back transactions separated by random gaps
   task automatic offer(input sym_req_type r, input bit typed, input sym_rsp_type want);
      sym_rsp_type res;
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid          <= 1'b1;
      req_func           <= r.func;
      req_entry_info     <= r.info;
      req_entry_start    <= r.start;
      req_entry_length   <= r.length;
      req_entry_name_ref <= r.name_ref;
      req_query_address  <= r.address;
      do @(posedge clock); while (req_stall !== 1'b0);
      res = resolve_symbol(r);
      if (typed)
         pending_rsp.push_back(want);
      else
         pending_rsp.push_back(res);
   endtask

   task automatic send(input sym_req_type r);
      sym_rsp_type none;
      none = '0;
      offer(r, 1'b0, none);
   endtask

   task automatic add_row(input logic [1:0] f, input logic [7:0] info,
                          input logic [srt_pkg::ADDR_BITS-1:0] st,
                          input logic [srt_pkg::LEN_W-1:0] len,
                          input logic [srt_pkg::NAME_W-1:0] nm,
                          input logic [srt_pkg::ADDR_BITS-1:0] addr,
                          input bit typed, input logic [1:0] ws,
                          input logic [srt_pkg::NAME_W-1:0] wn,
                          input logic [srt_pkg::OFF_W-1:0] wo);
      stim_row_type row;
      row.item.func     = f;
      row.item.info     = info;
      row.item.start    = st;
      row.item.length   = len;
      row.item.name_ref = nm;
      row.item.address  = addr;
      row.typed         = typed;
      row.want.status   = ws;
      row.want.name_ref = wn;
      row.want.offset   = wo;
      directed_rows.push_back(row);
   endtask

   // drop valid first so the last accepted transaction is not offered again
   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      sym_rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no transaction pending: status %0d", rsp_status);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_found_name_ref !== want.name_ref) begin
               $error("found_name_ref mismatch: expected %h, actual %h",
                      want.name_ref, rsp_found_name_ref);
               error_count++;
            end
            if (rsp_found_offset !== want.offset) begin
               $error("found_offset mismatch: expected %h, actual %h",
                      want.offset, rsp_found_offset);
               error_count++;
            end
            case (want.status)
               srt_pkg::STATUS_OK:      done_count++;
               srt_pkg::STATUS_SKIPPED: skipped_count++;
               srt_pkg::STATUS_FULL:    full_count++;
               default:                 miss_count++;
            endcase
         end
      end
   end

   // receiver: stall pattern of its own, plus one long hold-off on request
   initial begin
      rsp_stall  = 1'b0;
      stall_mode = 0;
      mode_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(10, 200);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle = 0;
         else
            idle++;
      end
      $display("symbol_range_table verification failed");
      $finish;
   end

   initial begin
      int  sent, ep, pick;
      bit  fill;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_func           = srt_pkg::FUNC_CLEAR;
      req_entry_info     = '0;
      req_entry_start    = '0;
      req_entry_length   = '0;
      req_entry_name_ref = '0;
      req_query_address  = '0;
      hold_off_req       = 1'b0;
      burst_left         = 0;
      model_count        = 0;
      error_count        = 0;
      done_count         = 0;
      skipped_count      = 0;
      full_count         = 0;
      miss_count         = 0;
      fill_count         = 0;
      cluster_base       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, '0,
              1, srt_pkg::STATUS_NOT_FOUND, '0, '0);
      add_row(FUNC_UNUSED, 8'h00, '0, '0, '0, '0, 1, srt_pkg::STATUS_OK, '0, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'h12, 48'h1000, 32'h100, 32'd5, '0,
              1, srt_pkg::STATUS_OK, '0, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'h02, 48'h2000, 32'h0, 32'd6, '0,
              1, srt_pkg::STATUS_SKIPPED, '0, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'h02, 48'h2000, 32'h10, 32'd0, '0,
              1, srt_pkg::STATUS_SKIPPED, '0, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'h03, 48'h2000, 32'h10, 32'd6, '0,
              1, srt_pkg::STATUS_SKIPPED, '0, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'hF2, MAX_ADDR, '1, '1, '0,
              1, srt_pkg::STATUS_OK, '0, '0);
      // address equal to a start is a hit at offset zero
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h1000,
              1, srt_pkg::STATUS_OK, 32'd5, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h10FF,
              1, srt_pkg::STATUS_OK, 32'd5, 32'hFF);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h1100,
              1, srt_pkg::STATUS_NOT_FOUND, '0, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h0FFF,
              1, srt_pkg::STATUS_NOT_FOUND, '0, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, MAX_ADDR,
              1, srt_pkg::STATUS_OK, '1, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'h22, 48'h1080, 32'h10, 32'd7, '0,
              1, srt_pkg::STATUS_OK, '0, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h1088,
              1, srt_pkg::STATUS_OK, 32'd7, 32'd8);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h1090,
              1, srt_pkg::STATUS_OK, 32'd5, 32'h90);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, '0,
              1, srt_pkg::STATUS_NOT_FOUND, '0, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'hFF, '1, '1, '1, 48'h8000_0000,
              0, srt_pkg::STATUS_OK, '0, '0);
      add_row(srt_pkg::FUNC_CLEAR, 8'hFF, '1, '1, '1, '1, 1, srt_pkg::STATUS_OK, '0, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'h1000,
              1, srt_pkg::STATUS_NOT_FOUND, '0, '0);
      add_row(srt_pkg::FUNC_LOAD, 8'h02, '0, 32'd1, 32'd1, '0,
              1, srt_pkg::STATUS_OK, '0, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, '0,
              1, srt_pkg::STATUS_OK, 32'd1, '0);
      add_row(srt_pkg::FUNC_LOOKUP, 8'h00, '0, '0, '0, 48'd1,
              1, srt_pkg::STATUS_NOT_FOUND, '0, '0);
      add_row(FUNC_UNUSED, 8'hFF, '1, '1, '1, '1, 1, srt_pkg::STATUS_OK, '0, '0);
      foreach (directed_rows[i])
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      sent = 0;
      ep   = 0;
      while (sent < RANDOM_ITEMS) begin
         fill = (ep == 6 || ep == 60);
         cluster_base = rand_addr();
         if (ep == 3) hold_off_req = 1'b1;
         if (ep % 8 == 5) wait_all_results();
         if (fill || $urandom_range(0, 3) == 0) begin
            send(noise_item(srt_pkg::FUNC_CLEAR));
            sent++;
         end
         if (fill) begin
            fill_count++;
            while (model_count < srt_pkg::MAX_ENTRIES) begin
               send(make_load(1'b1));
               sent++;
               if ($urandom_range(0, 15) == 0) begin
                  send(make_lookup());
                  sent++;
               end
            end
            // full table: valid entries are dropped, broken ones still skip
            repeat (8) begin
               send(make_load(1'($urandom_range(0, 1))));
               sent++;
            end
            repeat (6) begin
               send(make_lookup());
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 24)) begin
               pick = $urandom_range(0, 99);
               if (pick < 45) begin
                  send(make_load(1'b1));
                  sent++;
               end else if (pick < 55) begin
                  send(make_load(1'b0));
                  sent++;
               end else if (pick < 95) begin
                  send(make_lookup());
                  sent++;
               end else begin
                  send(noise_item(FUNC_UNUSED));
               end
            end
         end
         ep++;
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d results never arrived", pending_rsp.size());
         error_count++;
      end
      $display("checked %0d directed rows and %0d random transactions over %0d episodes",
               directed_rows.size(), sent, ep);
      $display("results: %0d done or found, %0d skipped, %0d table full, %0d not found, %0d fills",
               done_count, skipped_count, full_count, miss_count, fill_count);
      if (error_count == 0)
         $display("symbol_range_table verification clean");
      else
         $display("symbol_range_table verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/srt_pkg.sv
src/srt_ram.sv
src/srt_match.sv
src/symbol_range_table.sv
src/srt_checker.sv
tb/testbench.sv
